### rtl/core/cwag_pkg.sv
package cwag_pkg;

  localparam int MAX_KERNEL_SIDE_DEF = 8;
  localparam int MAX_MAP_SIDE_DEF    = 4096;
  localparam int QUEUE_DEPTH         = 2;

  typedef enum logic [2:0] {
    REG_IN_WIDTH      = 3'd0,
    REG_IN_HEIGHT     = 3'd1,
    REG_KERNEL_WIDTH  = 3'd2,
    REG_KERNEL_HEIGHT = 3'd3,
    REG_STRIDE_HORIZ  = 3'd4,
    REG_STRIDE_VERT   = 3'd5,
    REG_PAD_TOP       = 3'd6,
    REG_PAD_LEFT      = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [12:0] in_width;
    logic [12:0] in_height;
    logic [3:0]  kernel_width;
    logic [3:0]  kernel_height;
    logic [3:0]  stride_horiz;
    logic [3:0]  stride_vert;
    logic [2:0]  pad_top;
    logic [2:0]  pad_left;
  } cfg_t;

  typedef struct packed {
    logic [11:0] out_col;
    logic [11:0] out_row;
  } in_item_t;

  typedef struct packed {
    logic [23:0] source_pixel;
    logic        zero_fill;
    logic [6:0]  dest_position;
    logic        tap_last;
    logic        pair_ready;
  } out_item_t;

  // window origin of one output pixel, may sit in the padding (negative)
  typedef struct packed {
    logic signed [16:0] y0;
    logic signed [16:0] x0;
    logic               slot;
  } job_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

endpackage

### rtl/core/conv_window_im2col_address_gen_unit.sv
// im2col address generator. Each accepted output pixel (out_col, out_row) yields
// kernel_width*kernel_height copy beats, one per cycle, row-major over the kernel;
// the back-end tap iterator sets that rate while the two-entry job queue stays fed
// and out_stall is low, with a load step when the iterator has run dry. The first
// beat passes the window origin into the queue, the iterator load, the tap stage,
// then the pixel-index multiply into the output register. Taps outside the input
// map give zero_fill with source_pixel 0. The buffer column slot flips on every
// pixel; pair_ready marks the last beat of the second column. Config must only be
// written while idle.
module conv_window_im2col_address_gen_unit #(
  parameter int MAX_KERNEL_SIDE = cwag_pkg::MAX_KERNEL_SIDE_DEF,
  parameter int MAX_MAP_SIDE    = cwag_pkg::MAX_MAP_SIDE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [12:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  cwag_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cwag_pkg::out_item_t out_data
);
  import cwag_pkg::*;

  cfg_t      cfg_r, cfg_nxt;
  q_status_t q_stat;
  job_t      wr_job, rd_job;
  logic      push, pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_IN_WIDTH:      cfg_nxt.in_width      = cfg_wdata;
        REG_IN_HEIGHT:     cfg_nxt.in_height     = cfg_wdata;
        REG_KERNEL_WIDTH:  cfg_nxt.kernel_width  = cfg_wdata[3:0];
        REG_KERNEL_HEIGHT: cfg_nxt.kernel_height = cfg_wdata[3:0];
        REG_STRIDE_HORIZ:  cfg_nxt.stride_horiz  = cfg_wdata[3:0];
        REG_STRIDE_VERT:   cfg_nxt.stride_vert   = cfg_wdata[3:0];
        REG_PAD_TOP:       cfg_nxt.pad_top       = cfg_wdata[2:0];
        REG_PAD_LEFT:      cfg_nxt.pad_left      = cfg_wdata[2:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.in_width      <= 13'd1;
      cfg_r.in_height     <= 13'd1;
      cfg_r.kernel_width  <= 4'd3;
      cfg_r.kernel_height <= 4'd3;
      cfg_r.stride_horiz  <= 4'd1;
      cfg_r.stride_vert   <= 4'd1;
      cfg_r.pad_top       <= 3'd0;
      cfg_r.pad_left      <= 3'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cwag_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .q_stat   (q_stat),
    .push     (push),
    .job      (wr_job)
  );

  cwag_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .q_stat (q_stat)
  );

  cwag_back #(
    .MAX_KERNEL_SIDE (MAX_KERNEL_SIDE),
    .MAX_MAP_SIDE    (MAX_MAP_SIDE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_stat    (q_stat),
    .rd_job    (rd_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### rtl/core/cwag_front.sv
module cwag_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cwag_pkg::in_item_t in_data,
  input  cwag_pkg::cfg_t    cfg,
  input  cwag_pkg::q_status_t q_stat,
  output logic              push,
  output cwag_pkg::job_t    job
);
  import cwag_pkg::*;

  logic        slot_r, slot_nxt;
  logic [15:0] yp, xp;

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  assign yp = 16'({4'd0, in_data.out_row} * {12'd0, cfg.stride_vert});
  assign xp = 16'({4'd0, in_data.out_col} * {12'd0, cfg.stride_horiz});

  always_comb begin
    job.y0   = $signed({1'b0, yp}) - $signed({14'd0, cfg.pad_top});
    job.x0   = $signed({1'b0, xp}) - $signed({14'd0, cfg.pad_left});
    job.slot = slot_r;
    slot_nxt = push ? ~slot_r : slot_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= 1'b0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

endmodule

### rtl/core/cwag_queue.sv
module cwag_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  cwag_pkg::job_t      wr_job,
  input  logic                pop,
  output cwag_pkg::job_t      rd_job,
  output cwag_pkg::q_status_t q_stat
);
  import cwag_pkg::*;

  localparam int IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] Depth = CntW'(QUEUE_DEPTH);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(QUEUE_DEPTH - 1);

  job_t            mem [QUEUE_DEPTH];
  logic [IdxW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  assign q_stat.full      = (cnt_r == Depth);
  assign q_stat.not_empty = (cnt_r != '0);
  assign rd_job           = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastIdx) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastIdx) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### rtl/core/cwag_back.sv
module cwag_back #(
  parameter int MAX_KERNEL_SIDE = cwag_pkg::MAX_KERNEL_SIDE_DEF,
  parameter int MAX_MAP_SIDE    = cwag_pkg::MAX_MAP_SIDE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cwag_pkg::cfg_t      cfg,
  input  cwag_pkg::q_status_t q_stat,
  input  cwag_pkg::job_t      rd_job,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output cwag_pkg::out_item_t out_data
);
  import cwag_pkg::*;

  localparam logic [4:0]  KMax = 5'(MAX_KERNEL_SIDE);
  localparam logic [16:0] MMax = 17'(MAX_MAP_SIDE);

  function automatic logic [3:0] sat_k(input logic [3:0] v);
    logic [3:0] r;
    if (v == 4'd0) begin
      r = 4'd1;
    end else if ({1'b0, v} > KMax) begin
      r = KMax[3:0];
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [3:0]  kw, kh;
  logic [6:0]  taps;
  logic [12:0] w_sat, h_sat;

  // iterator over the taps of the current pixel
  logic               cur_valid_r, cur_valid_nxt;
  logic signed [16:0] iy_r, iy_nxt, ix_r, ix_nxt, x0_r, x0_nxt;
  logic [3:0]         kx_r, kx_nxt, ky_r, ky_nxt;
  logic [5:0]         t_r, t_nxt;
  logic               slot_r, slot_nxt;

  // tap stage, then output register (multiply sits between them)
  logic        s1_valid_r, s1_valid_nxt;
  logic [12:0] s1_iy_r, s1_ix_r;
  logic        s1_pad_r, s1_last_r, s1_pair_r;
  logic [6:0]  s1_dest_r;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_r;

  logic        adv, s1_take, emit, row_end, last_now, pad_now;
  logic [6:0]  dest_now;
  logic [25:0] prod, src_sum;

  always_comb begin
    kw    = sat_k(cfg.kernel_width);
    kh    = sat_k(cfg.kernel_height);
    taps  = 7'({3'd0, kw} * {3'd0, kh});
    w_sat = ({4'd0, cfg.in_width} > MMax) ? MMax[12:0] : cfg.in_width;
    h_sat = ({4'd0, cfg.in_height} > MMax) ? MMax[12:0] : cfg.in_height;
  end

  assign adv      = !out_valid_r || !out_stall;
  assign s1_take  = !s1_valid_r || adv;
  assign emit     = cur_valid_r && s1_take;
  assign row_end  = (kx_r == kw - 4'd1);
  assign last_now = row_end && (ky_r == kh - 4'd1);
  assign pop      = q_stat.not_empty && (!cur_valid_r || (emit && last_now));

  assign pad_now = iy_r[16] || (iy_r >= $signed({4'd0, h_sat})) ||
                   ix_r[16] || (ix_r >= $signed({4'd0, w_sat}));
  assign dest_now = {1'b0, t_r} + (slot_r ? taps : 7'd0);

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    iy_nxt   = iy_r;
    ix_nxt   = ix_r;
    x0_nxt   = x0_r;
    kx_nxt   = kx_r;
    ky_nxt   = ky_r;
    t_nxt    = t_r;
    slot_nxt = slot_r;
    if (emit) begin
      t_nxt = t_r + 6'd1;
      if (row_end) begin
        kx_nxt = 4'd0;
        ky_nxt = ky_r + 4'd1;
        ix_nxt = x0_r;
        iy_nxt = iy_r + 17'sd1;
      end else begin
        kx_nxt = kx_r + 4'd1;
        ix_nxt = ix_r + 17'sd1;
      end
      if (last_now) begin
        cur_valid_nxt = 1'b0;
      end
    end
    if (pop) begin
      cur_valid_nxt = 1'b1;
      iy_nxt   = rd_job.y0;
      ix_nxt   = rd_job.x0;
      x0_nxt   = rd_job.x0;
      kx_nxt   = 4'd0;
      ky_nxt   = 4'd0;
      t_nxt    = 6'd0;
      slot_nxt = rd_job.slot;
    end
  end

  always_comb begin
    s1_valid_nxt  = s1_take ? emit : s1_valid_r;
    out_valid_nxt = adv ? s1_valid_r : out_valid_r;
    prod          = 26'({13'd0, s1_iy_r} * {13'd0, w_sat});
    src_sum       = prod + {13'd0, s1_ix_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iy_r   <= iy_nxt;
    ix_r   <= ix_nxt;
    x0_r   <= x0_nxt;
    kx_r   <= kx_nxt;
    ky_r   <= ky_nxt;
    t_r    <= t_nxt;
    slot_r <= slot_nxt;
    if (emit) begin
      s1_iy_r   <= iy_r[12:0];
      s1_ix_r   <= ix_r[12:0];
      s1_pad_r  <= pad_now;
      s1_dest_r <= dest_now;
      s1_last_r <= last_now;
      s1_pair_r <= last_now && slot_r;
    end
    if (adv && s1_valid_r) begin
      out_r.source_pixel  <= s1_pad_r ? 24'd0 : src_sum[23:0];
      out_r.zero_fill     <= s1_pad_r;
      out_r.dest_position <= s1_dest_r;
      out_r.tap_last      <= s1_last_r;
      out_r.pair_ready    <= s1_pair_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### rtl/core/cwag_checker.sv
module cwag_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input cwag_pkg::out_item_t out_data
);
  import cwag_pkg::*;

  // a stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  a_pair_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.pair_ready |-> out_data.tap_last)
    else $error("pair_ready off the last tap");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_fill |-> out_data.source_pixel == 24'd0)
    else $error("zero fill beat with nonzero source");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind conv_window_im2col_address_gen_unit cwag_checker u_cwag_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
